// ===== rtl/ssc_pkg.sv =====
// Shared types, constants and the subrow coverage function of the span coverage block.
`timescale 1ns / 1ps
package ssc_pkg;

   localparam int PX_W              = 12;
   localparam int EDGE_W            = 15;
   localparam int NUM_ROWS          = 4;
   localparam int PIXELS_PER_RESULT = 8;
   localparam int MAX_SPAN_PIXELS   = 512;
   localparam int MAX_GROUPS        = 64;
   localparam int SPAN_LIMIT        = (MAX_SPAN_PIXELS < MAX_GROUPS * PIXELS_PER_RESULT)
                                      ? MAX_SPAN_PIXELS : MAX_GROUPS * PIXELS_PER_RESULT;
   localparam int REM_W             = $clog2(SPAN_LIMIT + 1);
   localparam int VC_W              = 4;
   localparam int SUB_W             = 3;

   // request tdata layout, lowest field first
   localparam int REQ_LEFT_LO  = 0;
   localparam int REQ_RIGHT_LO = REQ_LEFT_LO + PX_W;
   localparam int REQ_INV_LO   = REQ_RIGHT_LO + PX_W;
   localparam int REQ_MINOR_LO = REQ_INV_LO + NUM_ROWS;
   localparam int REQ_MAJOR_LO = REQ_MINOR_LO + NUM_ROWS * EDGE_W;
   localparam int REQ_USED_W   = REQ_MAJOR_LO + NUM_ROWS * EDGE_W;
   localparam int REQ_DATA_W   = ((REQ_USED_W + 7) / 8) * 8;

   // response tdata layout, lowest field first
   localparam int RSP_COV_LO  = PX_W;
   localparam int RSP_VC_LO   = RSP_COV_LO + 8 * PIXELS_PER_RESULT;
   localparam int RSP_USED_W  = RSP_VC_LO + VC_W;
   localparam int RSP_DATA_W  = ((RSP_USED_W + 7) / 8) * 8;

   localparam logic [7:0] LEFT_FILL  = 8'h0F;
   localparam logic [7:0] RIGHT_FILL = 8'hF0;
   localparam logic [3:0] EVEN_FM    = 4'b1010;

   // one subrow's edge data, resolved for flip at request time
   typedef struct packed {
      logic            en;
      logic [PX_W-1:0] ai;
      logic [PX_W-1:0] bi;
      logic [3:0]      lpart;
      logic [3:0]      rpart;
   } row_type;

   typedef row_type [NUM_ROWS-1:0] row_set_type;
   typedef logic [PIXELS_PER_RESULT-1:0][7:0] mask_set_type;

   // half-pixel rounded coverage of an edge fraction
   function automatic logic [SUB_W-1:0] half_cover(input logic [SUB_W-1:0] frac);
      logic [SUB_W:0] sum;
      sum = {1'b0, frac} + 4'd1;
      return sum[SUB_W:1];
   endfunction

   // checkerboard bit pair of a subrow
   function automatic logic [3:0] row_fm(input int r);
      return EVEN_FM >> (r % 2);
   endfunction

   // bits of one subrow at pixel px, unshifted, within fm
   function automatic logic [3:0] row_bits(input logic [PX_W-1:0] px, input row_type row,
                                           input logic [3:0] fm);
      logic [3:0] bits;
      bits = 4'h0;
      if (row.en) begin
         if (row.ai > row.bi) begin
            if (px == row.bi) begin
               bits = row.lpart;
            end else if (px == row.ai) begin
               bits = row.rpart;
            end else if (px > row.bi && px < row.ai) begin
               bits = fm;
            end
         end else if (row.ai == row.bi) begin
            if (px == row.ai) begin
               bits = row.lpart & row.rpart;
            end
         end
      end
      return bits;
   endfunction

endpackage

// ===== rtl/ssc_lane.sv =====
// One pixel lane: coverage mask of a single pixel over the four subrows.
`timescale 1ns / 1ps
module ssc_lane (
   input  logic [ssc_pkg::PX_W-1:0] px,
   input  ssc_pkg::row_set_type     rows,
   output logic [7:0]               mask
);
   import ssc_pkg::*;

   // gather each subrow's bit pair into its nibble
   always_comb begin
      mask = 8'h00;
      for (int r = 0; r < NUM_ROWS; r++) begin
         if (r < 2) begin
            mask = mask | {row_bits(px, rows[r], row_fm(r)), 4'h0};
         end else begin
            mask = mask | {4'h0, row_bits(px, rows[r], row_fm(r))};
         end
      end
   end

endmodule

// ===== rtl/ssc_merge.sv =====
// Merge stage: packs the lane masks into one group, clearing lanes past the span end.
`timescale 1ns / 1ps
module ssc_merge (
   input  ssc_pkg::mask_set_type                               masks,
   input  logic [ssc_pkg::VC_W-1:0]                            count,
   output logic [8*ssc_pkg::PIXELS_PER_RESULT-1:0]             bytes
);
   import ssc_pkg::*;

   // keep lane k only below the valid count
   always_comb begin
      for (int k = 0; k < PIXELS_PER_RESULT; k++) begin
         bytes[8*k +: 8] = (VC_W'(k) < count) ? masks[k] : 8'h00;
      end
   end

endmodule

// ===== rtl/span_subpixel_coverage.sv =====
// Top level: span capture, group sequencer, pixel lanes and response register.
`timescale 1ns / 1ps
// A span is accepted while the block is idle. It then issues one group of eight pixel coverage
// masks per cycle unless the response register is full and rsp_tready is low, ceil(pixels / 8)
// groups in all and at most 64, from the eight-lane pixel array; req_tready stays low meanwhile.
// An empty span (end before start) is accepted and gives no transaction. Spans
// over 512 pixels are cut to 512 and every group carries the clipped flag. A response register
// holds each group, so the next span is taken while the last group still waits on rsp_tready.
module span_subpixel_coverage (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // span_left, span_right, invalid_rows, minor_x0..3, major_x0..3, zero pad
   input  logic [ssc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // flip
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // group_start_x, coverage_bytes, valid_count
   output logic [ssc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // clipped
   output logic                               rsp_tuser,
   // last_group
   output logic                               rsp_tlast
);
   import ssc_pkg::*;

   logic                         busy_ff, busy_in;
   logic [PX_W-1:0]              cur_ff, cur_in;
   logic [REM_W-1:0]             rem_ff, rem_in;
   logic                         clip_ff, clip_in;
   row_set_type                  rows_ff, rows_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [PX_W-1:0]              rsp_start_ff;
   logic [8*PIXELS_PER_RESULT-1:0] rsp_bytes_ff, grp_bytes;
   logic [VC_W-1:0]              rsp_count_ff, grp_count;
   logic                         rsp_last_ff, grp_last;
   logic                         rsp_clip_ff;

   logic                         req_accept, advance, span_empty, span_clip;
   logic [PX_W-1:0]              span_start, span_end;
   logic [PX_W:0]                span_count;
   mask_set_type                 lane_masks;

   assign req_tready = !busy_ff;
   assign req_accept = req_tvalid && req_tready;
   assign advance    = busy_ff && (!rsp_valid_ff || rsp_tready);

   // resolve bounds and pixel count of the incoming span
   always_comb begin
      span_start = req_tuser ? req_tdata[REQ_RIGHT_LO +: PX_W] : req_tdata[REQ_LEFT_LO +: PX_W];
      span_end   = req_tuser ? req_tdata[REQ_LEFT_LO +: PX_W]  : req_tdata[REQ_RIGHT_LO +: PX_W];
      span_empty = span_end < span_start;
      span_count = {1'b0, span_end} - {1'b0, span_start} + (PX_W + 1)'(1);
      span_clip  = span_count > (PX_W + 1)'(SPAN_LIMIT);
   end

   // resolve edge roles and partial bits of each subrow
   always_comb begin
      logic [EDGE_W-1:0] mn, mj, ea, eb;
      for (int r = 0; r < NUM_ROWS; r++) begin
         mn = req_tdata[REQ_MINOR_LO + r*EDGE_W +: EDGE_W];
         mj = req_tdata[REQ_MAJOR_LO + r*EDGE_W +: EDGE_W];
         ea = req_tuser ? mn : mj;
         eb = req_tuser ? mj : mn;
         rows_in[r].en    = !req_tdata[REQ_INV_LO + r];
         rows_in[r].ai    = ea[EDGE_W-1:SUB_W];
         rows_in[r].bi    = eb[EDGE_W-1:SUB_W];
         rows_in[r].lpart = 4'(LEFT_FILL  >> half_cover(eb[SUB_W-1:0])) & row_fm(r);
         rows_in[r].rpart = 4'(RIGHT_FILL >> half_cover(ea[SUB_W-1:0])) & row_fm(r);
      end
   end

   // pixel lanes of the current group
   for (genvar k = 0; k < PIXELS_PER_RESULT; k++) begin : g_lane
      ssc_lane u_lane (
         .px   (cur_ff + PX_W'(k)),
         .rows (rows_ff),
         .mask (lane_masks[k])
      );
   end

   // group size and final group flag
   always_comb begin
      grp_last  = rem_ff <= REM_W'(PIXELS_PER_RESULT);
      grp_count = grp_last ? rem_ff[VC_W-1:0] : VC_W'(PIXELS_PER_RESULT);
   end

   ssc_merge u_merge (
      .masks (lane_masks),
      .count (grp_count),
      .bytes (grp_bytes)
   );

   // sequencer: load a span, advance one group per issued transaction
   always_comb begin
      busy_in = busy_ff;
      cur_in  = cur_ff;
      rem_in  = rem_ff;
      clip_in = clip_ff;
      if (req_accept) begin
         busy_in = !span_empty;
         cur_in  = span_start;
         rem_in  = span_clip ? REM_W'(SPAN_LIMIT) : span_count[REM_W-1:0];
         clip_in = span_clip;
      end else if (advance) begin
         busy_in = !grp_last;
         cur_in  = cur_ff + PX_W'(PIXELS_PER_RESULT);
         rem_in  = rem_ff - REM_W'(grp_count);
      end
   end

   // response register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold span data and response payload
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      rem_ff  <= rem_in;
      clip_ff <= clip_in;
      if (req_accept) begin
         rows_ff <= rows_in;
      end
      if (advance) begin
         rsp_start_ff <= cur_ff;
         rsp_bytes_ff <= grp_bytes;
         rsp_count_ff <= grp_count;
         rsp_last_ff  <= grp_last;
         rsp_clip_ff  <= clip_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_count_ff, rsp_bytes_ff, rsp_start_ff});
   assign rsp_tuser  = rsp_clip_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_full_unless_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_count_ff == VC_W'(PIXELS_PER_RESULT)))
      else $error("non-final group is not full");

   a_empty_span_idle: assert property (@(posedge clock) disable iff (reset)
      (req_accept && span_empty) |=> !busy_ff)
      else $error("empty span started a run");

   a_busy_has_work: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff != '0))
      else $error("busy with no pixels left");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (advance && grp_last) |=> !busy_ff)
      else $error("run continued past its final group");

endmodule
